// ----- rtl/rcst_pkg.sv -----
// Package for the named refcount slot table.
// Holds field widths, opcode and status codes, FSM states, memory entry type
// and the name helpers. No dependencies.
package rcst_pkg;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEF      = 8;
   localparam int NAME_BYTES_DEF = 8;

   // Fixed field widths
   localparam int KEY_W       = 64;
   localparam int BYTE_W      = 8;
   localparam int KEY_BYTES   = KEY_W / BYTE_W;
   localparam int SLOT_FLD_W  = 3;
   localparam int REFS_W      = 16;

   // Request opcodes
   localparam logic OP_OPEN    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Response status codes
   typedef enum logic [2:0] {
      STAT_FOUND    = 3'd0,
      STAT_ALLOC    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_RELEASED = 3'd3,
      STAT_IGNORED  = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // One slot entry as kept in the slot memory
   typedef struct packed {
      logic [KEY_W-1:0]  name;
      logic [REFS_W-1:0] refs;
   } entry_type;

   // Keep the first nb name bytes, zero the rest
   function automatic logic [KEY_W-1:0] name_mask(logic [KEY_W-1:0] key, int nb);
      logic [KEY_W-1:0] masked;
      masked = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (i < nb) begin
            masked[i*BYTE_W +: BYTE_W] = key[i*BYTE_W +: BYTE_W];
         end
      end
      return masked;
   endfunction

   // Compare byte by byte up to and including the first zero byte
   function automatic logic names_match(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      logic result;
      logic stop;
      result = 1'b1;
      stop   = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (!stop) begin
            if (a[i*BYTE_W +: BYTE_W] != b[i*BYTE_W +: BYTE_W]) begin
               result = 1'b0;
               stop   = 1'b1;
            end else if (a[i*BYTE_W +: BYTE_W] == '0) begin
               stop = 1'b1;
            end
         end
      end
      return result;
   endfunction

endpackage

// ----- rtl/rcst_if.sv -----
// Valid/ready channel interfaces for the named refcount slot table.
// Depends on rcst_pkg for field widths and the status type.
interface rcst_req_if;
   logic                            valid;
   logic                            ready;
   logic                            op;
   logic [rcst_pkg::KEY_W-1:0]      name_key;
   logic [rcst_pkg::SLOT_FLD_W-1:0] slot;

   modport source (output valid, op, name_key, slot, input ready);
   modport sink   (input valid, op, name_key, slot, output ready);
endinterface

interface rcst_rsp_if;
   logic                            valid;
   logic                            ready;
   rcst_pkg::status_type            status;
   logic [rcst_pkg::SLOT_FLD_W-1:0] slot_out;
   logic [rcst_pkg::REFS_W-1:0]     ref_count;

   modport source (output valid, status, slot_out, ref_count, input ready);
   modport sink   (input valid, status, slot_out, ref_count, output ready);
endinterface

// ----- rtl/named_refcount_slot_table.sv -----
// Named refcount slot table. One item is in work at a time. A release, or an
// open on a full table, gives its result the cycle after acceptance. An open
// scans the slot memory one entry per cycle through its single read port and
// compares each entry in the cycle after its read; its result is registered
// when slot i holds the name, or after the last slot is checked when a new
// slot is allocated. The next item is accepted the cycle after the result is
// taken. All slots are free right after reset; there is no clearing pass.
// Depends on rcst_pkg, rcst_if, rcst_mem and rcst_ctrl.
module named_refcount_slot_table #(
   parameter int SLOTS      = rcst_pkg::SLOTS_DEF,
   parameter int NAME_BYTES = rcst_pkg::NAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rcst_req_if.sink    req_ch,
   rcst_rsp_if.source  rsp_ch
);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   rcst_pkg::entry_type mem_wr_data;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   rcst_pkg::entry_type mem_rd_data;

   rcst_ctrl #(
      .SLOTS      (SLOTS),
      .NAME_BYTES (NAME_BYTES),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rcst_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // A release answers in the next cycle with a released or ignored status for that slot
   a_release_resp: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == rcst_pkg::OP_RELEASE) |=>
      (rsp_ch.valid && rsp_ch.ref_count == '0 && rsp_ch.slot_out == $past(req_ch.slot)
       && (rsp_ch.status == rcst_pkg::STAT_RELEASED
           || rsp_ch.status == rcst_pkg::STAT_IGNORED)))
      else $error("release did not answer next cycle");

   // No new item is taken while a result is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while result pending");

   // A fresh slot always starts at one reference
   a_alloc_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == rcst_pkg::STAT_ALLOC) |-> rsp_ch.ref_count == 1)
      else $error("allocated slot count is not one");

   // A full table reports slot zero and count zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == rcst_pkg::STAT_FULL) |->
      (rsp_ch.slot_out == '0 && rsp_ch.ref_count == '0))
      else $error("full result carries nonzero fields");
endmodule

// ----- rtl/rcst_mem.sv -----
// Slot memory: name and reference count per slot, one write and one read
// port, registered read data. Depends on rcst_pkg for the entry type.
module rcst_mem #(
   parameter int DEPTH  = rcst_pkg::SLOTS_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  rcst_pkg::entry_type       wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output rcst_pkg::entry_type       rd_data
);
   rcst_pkg::entry_type store_ff [DEPTH];
   rcst_pkg::entry_type rd_data_ff;

   // Write entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read entry, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/rcst_ctrl.sv -----
// Controller of the slot table: request handshake, slot valid bits, active
// count, name scan over the slot memory and the response register.
// Depends on rcst_pkg and the channel interfaces in rcst_if.
module rcst_ctrl #(
   parameter int SLOTS      = rcst_pkg::SLOTS_DEF,
   parameter int NAME_BYTES = rcst_pkg::NAME_BYTES_DEF,
   parameter int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   rcst_req_if.sink             req,
   rcst_rsp_if.source           rsp,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output rcst_pkg::entry_type  mem_wr_data,
   output logic                 mem_rd_en,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  rcst_pkg::entry_type  mem_rd_data
);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   rcst_pkg::state_type              state_ff, state_in;
   logic [SLOTS-1:0]                 valid_ff, valid_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [rcst_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [IDX_W-1:0]                 scan_idx_ff, scan_idx_in;
   logic                             issue_done_ff, issue_done_in;
   logic                             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]                 chk_idx_ff, chk_idx_in;
   logic                             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]                 free_idx_ff, free_idx_in;
   rcst_pkg::status_type             status_ff, status_in;
   logic [rcst_pkg::SLOT_FLD_W-1:0]  slot_out_ff, slot_out_in;
   logic [rcst_pkg::REFS_W-1:0]      refs_ff, refs_in;

   logic                             accept;
   logic                             full;
   logic                             sel_ok;
   logic [IDX_W-1:0]                 sel_idx;
   logic                             issue;
   logic                             hit;
   logic                             last_chk;
   logic                             free_here;
   logic [IDX_W-1:0]                 alloc_idx;
   logic [rcst_pkg::REFS_W-1:0]      refs_inc;

   // Handshake and scan status
   always_comb begin
      accept    = req.valid && (state_ff == rcst_pkg::ST_IDLE);
      full      = (count_ff == CNT_W'(SLOTS));
      sel_idx   = IDX_W'(req.slot);
      sel_ok    = (32'(req.slot) < SLOTS) && valid_ff[sel_idx];
      issue     = (state_ff == rcst_pkg::ST_SCAN) && !issue_done_ff;
      hit       = chk_vld_ff && valid_ff[chk_idx_ff]
                  && rcst_pkg::names_match(mem_rd_data.name, key_ff);
      last_chk  = chk_vld_ff && (chk_idx_ff == LAST_IDX);
      free_here = chk_vld_ff && !valid_ff[chk_idx_ff];
      alloc_idx = free_vld_ff ? free_idx_ff : chk_idx_ff;
      refs_inc  = (mem_rd_data.refs == '1) ? mem_rd_data.refs
                                           : mem_rd_data.refs + 1'b1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcst_pkg::ST_IDLE: begin
            if (accept) begin
               if (req.op == rcst_pkg::OP_RELEASE || full) begin
                  state_in = rcst_pkg::ST_RESP;
               end else begin
                  state_in = rcst_pkg::ST_SCAN;
               end
            end
         end
         rcst_pkg::ST_SCAN: begin
            if (hit || last_chk) begin
               state_in = rcst_pkg::ST_RESP;
            end
         end
         rcst_pkg::ST_RESP: begin
            if (rsp.ready) begin
               state_in = rcst_pkg::ST_IDLE;
            end
         end
         default: state_in = rcst_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      valid_in      = valid_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      status_in     = status_ff;
      slot_out_in   = slot_out_ff;
      refs_in       = refs_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = chk_idx_ff;
      mem_wr_data   = '{name: key_ff, refs: refs_inc};
      mem_rd_en     = issue;
      mem_rd_addr   = scan_idx_ff;
      case (state_ff)
         rcst_pkg::ST_IDLE: begin
            if (accept) begin
               key_in        = rcst_pkg::name_mask(req.name_key, NAME_BYTES);
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               chk_vld_in    = 1'b0;
               free_vld_in   = 1'b0;
               refs_in       = '0;
               if (req.op == rcst_pkg::OP_RELEASE) begin
                  // Release: clear the slot if it is active
                  slot_out_in = req.slot;
                  if (sel_ok) begin
                     valid_in[sel_idx] = 1'b0;
                     count_in          = count_ff - 1'b1;
                     status_in         = rcst_pkg::STAT_RELEASED;
                  end else begin
                     status_in = rcst_pkg::STAT_IGNORED;
                  end
               end else begin
                  status_in   = rcst_pkg::STAT_FULL;
                  slot_out_in = '0;
               end
            end
         end
         rcst_pkg::ST_SCAN: begin
            // Advance the read pointer, check the entry read last cycle
            chk_vld_in = issue;
            chk_idx_in = scan_idx_ff;
            if (issue) begin
               scan_idx_in   = scan_idx_ff + 1'b1;
               issue_done_in = (scan_idx_ff == LAST_IDX);
            end
            if (free_here && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = chk_idx_ff;
            end
            if (hit) begin
               // Existing name: bump the saturating count
               mem_wr_en   = 1'b1;
               status_in   = rcst_pkg::STAT_FOUND;
               slot_out_in = rcst_pkg::SLOT_FLD_W'(chk_idx_ff);
               refs_in     = refs_inc;
            end else if (last_chk) begin
               // No match: take the lowest free slot
               mem_wr_en            = 1'b1;
               mem_wr_addr          = alloc_idx;
               mem_wr_data          = '{name: key_ff, refs: rcst_pkg::REFS_W'(1)};
               valid_in[alloc_idx]  = 1'b1;
               count_in             = count_ff + 1'b1;
               status_in            = rcst_pkg::STAT_ALLOC;
               slot_out_in          = rcst_pkg::SLOT_FLD_W'(alloc_idx);
               refs_in              = rcst_pkg::REFS_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rcst_pkg::ST_IDLE;
         valid_ff      <= '0;
         count_ff      <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         free_vld_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= chk_vld_in;
         free_vld_ff   <= free_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      slot_out_ff <= slot_out_in;
      refs_ff     <= refs_in;
   end

   // Channel outputs
   always_comb begin
      req.ready     = (state_ff == rcst_pkg::ST_IDLE);
      rsp.valid     = (state_ff == rcst_pkg::ST_RESP);
      rsp.status    = status_ff;
      rsp.slot_out  = slot_out_ff;
      rsp.ref_count = refs_ff;
   end
endmodule

// ----- test/rcst_table_checker.sv -----
// Response checker for the named refcount slot table: mirrors the slot state,
// predicts one response per accepted request and compares them in order.
// Depends on rcst_pkg and the channel interfaces in rcst_if.
module rcst_table_checker #(
   parameter int SLOTS      = rcst_pkg::SLOTS_DEF,
   parameter int NAME_BYTES = rcst_pkg::NAME_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   rcst_req_if  req_mon,
   rcst_rsp_if  rsp_mon,
   output int   fail_count,
   output int   waiting,
   output int   checked
);
   typedef struct {
      rcst_pkg::status_type              status;
      logic [rcst_pkg::SLOT_FLD_W-1:0]   slot;
      logic [rcst_pkg::REFS_W-1:0]       refs;
   } slot_rsp_type;

   slot_rsp_type                expected_rsps[$];
   logic                        slot_busy [SLOTS];
   logic [rcst_pkg::KEY_W-1:0]  slot_tag  [SLOTS];
   logic [rcst_pkg::REFS_W-1:0] slot_cnt  [SLOTS];
   int                          busy_total;

   // Keep the bytes that belong to a name, zero the rest
   function automatic logic [rcst_pkg::KEY_W-1:0] trim_name(
         input logic [rcst_pkg::KEY_W-1:0] key);
      logic [rcst_pkg::KEY_W-1:0] kept;
      kept = '0;
      for (int b = 0; b < NAME_BYTES && b < rcst_pkg::KEY_BYTES; b++)
         kept[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W] =
            key[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W];
      return kept;
   endfunction

   // Names are equal up to and including the first zero byte
   function automatic logic same_name(input logic [rcst_pkg::KEY_W-1:0] stored,
                                      input logic [rcst_pkg::KEY_W-1:0] key);
      for (int b = 0; b < NAME_BYTES && b < rcst_pkg::KEY_BYTES; b++) begin
         if (stored[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W]
             != key[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W])
            return 1'b0;
         if (stored[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W] == '0)
            return 1'b1;
      end
      return 1'b1;
   endfunction

   // Apply one request to the mirrored table and return its response
   function automatic slot_rsp_type apply_request(
         input logic op,
         input logic [rcst_pkg::KEY_W-1:0] key,
         input logic [rcst_pkg::SLOT_FLD_W-1:0] sel);
      slot_rsp_type r;
      int           hit;
      r.status = rcst_pkg::STAT_FULL;
      r.slot   = '0;
      r.refs   = '0;
      hit      = -1;
      if (op == rcst_pkg::OP_RELEASE) begin
         r.slot = sel;
         if (sel < SLOTS && slot_busy[sel]) begin
            slot_busy[sel] = 1'b0;
            slot_tag[sel]  = '0;
            slot_cnt[sel]  = '0;
            busy_total--;
            r.status = rcst_pkg::STAT_RELEASED;
         end else begin
            r.status = rcst_pkg::STAT_IGNORED;
         end
         return r;
      end
      // A full table refuses every open, even a known name
      if (busy_total >= SLOTS)
         return r;
      for (int s = 0; s < SLOTS; s++)
         if (hit < 0 && slot_busy[s] && same_name(slot_tag[s], key))
            hit = s;
      if (hit >= 0) begin
         if (slot_cnt[hit] != '1)
            slot_cnt[hit] = slot_cnt[hit] + 1'b1;
         r.status = rcst_pkg::STAT_FOUND;
         r.slot   = hit[rcst_pkg::SLOT_FLD_W-1:0];
         r.refs   = slot_cnt[hit];
         return r;
      end
      // Take the lowest free slot
      for (int s = 0; s < SLOTS; s++)
         if (hit < 0 && !slot_busy[s])
            hit = s;
      slot_busy[hit] = 1'b1;
      slot_tag[hit]  = trim_name(key);
      slot_cnt[hit]  = rcst_pkg::REFS_W'(1);
      busy_total++;
      r.status = rcst_pkg::STAT_ALLOC;
      r.slot   = hit[rcst_pkg::SLOT_FLD_W-1:0];
      r.refs   = rcst_pkg::REFS_W'(1);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      slot_rsp_type want;
      if (reset) begin
         expected_rsps.delete();
         for (int s = 0; s < SLOTS; s++) begin
            slot_busy[s] = 1'b0;
            slot_tag[s]  = '0;
            slot_cnt[s]  = '0;
         end
         busy_total = 0;
         fail_count = 0;
         checked    = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(apply_request(req_mon.op, req_mon.name_key,
                                                  req_mon.slot));
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with no request pending", rsp_mon.status, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.slot_out !== want.slot)
                  report_mismatch("slot_out", rsp_mon.slot_out, want.slot);
               if (rsp_mon.ref_count !== want.refs)
                  report_mismatch("ref_count", rsp_mon.ref_count, want.refs);
            end
         end
      end
      waiting = expected_rsps.size();
   end

endmodule

// ----- test/tb.sv -----
// Top of the slot table testbench: clock, reset, request stimulus and
// response flow control; the checker beside the block does the comparing.
// Depends on rcst_pkg, rcst_if, the block and rcst_table_checker.
module tb;
   localparam int LIMIT_CYCLES = 200_000;
   localparam int POOL_SIZE    = 12;
   localparam int RANDOM_ITEMS = 1420;
   localparam int BURST_OPENS  = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   logic                       clock;
   logic                       reset;
   logic                       gaps_on;
   logic                       hold_asked;
   logic                       hold_done;
   int                         fail_count;
   int                         waiting;
   int                         checked;
   int                         items_sent;
   int                         cycles;
   logic [rcst_pkg::KEY_W-1:0] name_pool [POOL_SIZE];
   int                         name_len  [POOL_SIZE];

   rcst_req_if req_ch ();
   rcst_rsp_if rsp_ch ();

   named_refcount_slot_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rcst_table_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .waiting    (waiting),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d responses pending", cycles, waiting);
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 14);
         end
      end
   end

   // Offer one item and hold it until it is taken
   task automatic send_item(input logic op, input logic [rcst_pkg::KEY_W-1:0] key,
                            input logic [rcst_pkg::SLOT_FLD_W-1:0] sel);
      while (gaps_on && $urandom_range(0, 99) < 14) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.name_key <= key;
      req_ch.slot     <= sel;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Drop valid and wait until every response has come back
   task automatic wait_empty();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (waiting != 0);
   endtask

   // Fill the bytes after the terminator with noise
   function automatic logic [rcst_pkg::KEY_W-1:0] with_random_tail(
         input logic [rcst_pkg::KEY_W-1:0] name);
      logic [rcst_pkg::KEY_W-1:0] key;
      logic                       ended;
      key   = name;
      ended = 1'b0;
      for (int b = 0; b < rcst_pkg::KEY_BYTES; b++) begin
         if (ended)
            key[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W] =
               rcst_pkg::BYTE_W'($urandom_range(0, 255));
         else if (name[b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W] == '0)
            ended = 1'b1;
      end
      return key;
   endfunction

   function automatic logic [rcst_pkg::KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [rcst_pkg::SLOT_FLD_W-1:0] random_slot();
      return rcst_pkg::SLOT_FLD_W'($urandom_range(0, 7));
   endfunction

   initial begin
      int pick;
      int release_pct;
      reset        = 1'b1;
      gaps_on      = 1'b1;
      hold_asked   = 1'b0;
      items_sent   = 0;
      req_ch.valid    = 1'b0;
      req_ch.op       = rcst_pkg::OP_OPEN;
      req_ch.name_key = '0;
      req_ch.slot     = '0;

      // Build a name pool; odd entries extend the previous name by one byte where it has room
      for (int p = 0; p < POOL_SIZE; p++) begin
         if (p % 2 == 1 && name_len[p-1] < rcst_pkg::KEY_BYTES) begin
            name_pool[p] = name_pool[p-1];
            name_len[p]  = name_len[p-1] + 1;
            name_pool[p][name_len[p-1]*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W] =
               rcst_pkg::BYTE_W'($urandom_range(1, 255));
         end else begin
            name_pool[p] = '0;
            name_len[p]  = $urandom_range(0, rcst_pkg::KEY_BYTES);
            for (int b = 0; b < name_len[p]; b++)
               name_pool[p][b*rcst_pkg::BYTE_W +: rcst_pkg::BYTE_W] =
                  rcst_pkg::BYTE_W'($urandom_range(1, 255));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty names, tails past the terminator, full table, releases
      send_item(rcst_pkg::OP_RELEASE, '0, 3'd3);
      send_item(rcst_pkg::OP_OPEN, 64'h0, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'hFFFF_0000_0000_FF00, 3'd7);
      send_item(rcst_pkg::OP_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_0041, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h00AB_CD00_0000_0041, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_4241, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_0142, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h8000_0000_0000_0001, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_0001, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h7F7F_7F7F_7F7F_7F7F, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0102_0304_0506_0708, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_0041, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_0099, 3'd0);
      send_item(rcst_pkg::OP_RELEASE, '1, 3'd7);
      send_item(rcst_pkg::OP_RELEASE, '0, 3'd7);
      send_item(rcst_pkg::OP_OPEN, 64'h0000_0000_0000_0055, 3'd0);
      send_item(rcst_pkg::OP_RELEASE, '0, 3'd0);
      send_item(rcst_pkg::OP_OPEN, 64'h0, 3'd0);
      for (int s = 0; s < 8; s++)
         send_item(rcst_pkg::OP_RELEASE, '0, s[rcst_pkg::SLOT_FLD_W-1:0]);
      send_item(rcst_pkg::OP_RELEASE, '0, 3'd0);
      wait_empty();

      // Build up one name's count with back-to-back opens
      gaps_on = 1'b0;
      for (int n = 0; n < BURST_OPENS; n++)
         send_item(rcst_pkg::OP_OPEN, 64'h0000_0053_5441_5453, 3'd0);
      send_item(rcst_pkg::OP_RELEASE, '0, 3'd0);
      wait_empty();

      // Random: opens mostly of pool names so slots get shared, some raw keys, and releases
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_on = !(n >= 800 && n < 1100);
         if (n == 300)
            hold_asked = 1'b1;
         release_pct = ((n / 150) % 2 == 1) ? 45 : 20;
         pick = $urandom_range(0, 99);
         if (pick < release_pct)
            send_item(rcst_pkg::OP_RELEASE, random_key(), random_slot());
         else if (pick < release_pct + 10)
            send_item(rcst_pkg::OP_OPEN, random_key(), random_slot());
         else
            send_item(rcst_pkg::OP_OPEN,
                      with_random_tail(name_pool[$urandom_range(0, POOL_SIZE - 1)]),
                      random_slot());
      end

      // Drain, then let the block run idle before the summary
      wait_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses: shared names, full table,",
               items_sent, checked);
      $display("releases of free and busy slots, a deep shared count and a long output stall.");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rcst_pkg.sv
rtl/rcst_if.sv
rtl/rcst_mem.sv
rtl/rcst_ctrl.sv
rtl/named_refcount_slot_table.sv
test/rcst_table_checker.sv
test/tb.sv
